[src/ax25e_pkg.sv]
// Shared types, constants and the FCS byte update for the AX.25 frame encoder.
package ax25e_pkg;

	localparam int unsigned LENGTH_LIMIT = 1023;
	localparam int unsigned CAP_W = 10;
	localparam int unsigned LEN_W = 10;
	localparam logic [3:0] ADDR_FULL = 4'd14;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [CAP_W-1:0] CAP_RESET = 10'd330;
	localparam logic [1:0] RES_DEPTH = 2'd3;

	typedef enum logic [1:0] {
		OP_ADDR = 2'd0,
		OP_CTRL = 2'd1,
		OP_PID  = 2'd2,
		OP_INFO = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_CAPACITY  = 2'd1,
		ST_ADDRESSES = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             out_last;
		status_t          status;
		logic [LEN_W-1:0] frame_length;
	} res_t;

	// one byte of the reflected CRC-16 (x^16 + x^12 + x^5 + 1), LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[src/ax25_frame_encoder_with_fcs.sv]
// AX.25 frame encoder: E-bit marking, PID filtering, FCS append and length check.
// An input transfer reaches the master side through the input register and then the result buffer.
// Throughput: one input byte per cycle while m_tready is high; a byte marked tlast yields
// three results (data byte and two FCS bytes; two if it is a dropped PID) and holds s_tready
// low while the three-entry result buffer drains.
// Reset (arst_n low, asynchronous): buffers empty, CRC 0xFFFF, counters zero,
// output_capacity 330.
module ax25_frame_encoder_with_fcs
	import ax25e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [2:0]  s_tuser,   // [1:0] opcode, [2] final_address_byte
	input  logic        s_tlast,   // last_byte
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [17:8] frame_length, [23:18] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast,   // out_last
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration register
	logic [CAP_W-1:0] cap_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	opcode_t    op_s1;
	logic       fin_s1;
	logic       last_s1;

	// frame state
	logic [15:0]      crc_q;
	logic [LEN_W-1:0] bw_q;
	logic [3:0]       addr_q;
	logic             ui_q;
	logic             discard_q;

	// result buffer, slot 0 is presented
	res_t       res_q [3];
	logic [1:0] cnt_q;

	logic             proceed;
	logic             pop;
	logic             emit;
	logic [1:0]       need;
	logic [11:0]      sum;
	logic [CAP_W-1:0] bound;
	logic             addr_err;
	logic             cap_err;
	logic [7:0]       byte_fix;
	logic [15:0]      crc_upd;
	logic [15:0]      crc_after;
	logic [15:0]      fcs;
	res_t             new_res [3];
	logic [1:0]       new_cnt;

	assign pready = 1'b1;
	assign prdata = {{(32-CAP_W){1'b0}}, cap_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign pop      = m_tvalid && m_tready;
	assign proceed  = valid_s1 && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_tready));
	assign s_tready = !valid_s1 || proceed;

	always_comb begin
		bound = ({7'd0, cap_q} > 17'(LENGTH_LIMIT)) ? CAP_W'(LENGTH_LIMIT) : cap_q;
		emit = (op_s1 != OP_PID) || ui_q;
		need = {last_s1, 1'b0} + {1'b0, emit};
		sum = {2'b00, bw_q} + {10'd0, need};
		addr_err = ((op_s1 != OP_ADDR) || last_s1) && (addr_q < ADDR_FULL);
		cap_err = sum > {2'b00, bound};
		byte_fix = {byte_s1[7:1], byte_s1[0] | ((op_s1 == OP_ADDR) && fin_s1)};
		crc_upd = crc_byte(crc_q, byte_fix);
		crc_after = emit ? crc_upd : crc_q;
		fcs = ~crc_after;

		for (int i = 0; i < 3; i++) begin
			new_res[i] = '{out_byte: 8'h00, out_last: 1'b0, status: ST_OK,
				frame_length: '0};
		end
		new_cnt = 2'd0;

		if (discard_q) begin
			new_cnt = 2'd0;
		end else if (addr_err || cap_err) begin
			new_res[0].out_last = 1'b1;
			new_res[0].status = addr_err ? ST_ADDRESSES : ST_CAPACITY;
			new_cnt = 2'd1;
		end else begin
			if (emit) begin
				new_res[0].out_byte = byte_fix;
			end
			if (last_s1) begin
				// FCS pair goes after the data byte, or first if the PID was dropped
				new_res[emit ? 2'd1 : 2'd0].out_byte = fcs[7:0];
				new_res[emit ? 2'd2 : 2'd1].out_byte = fcs[15:8];
				new_res[emit ? 2'd2 : 2'd1].out_last = 1'b1;
				new_res[emit ? 2'd2 : 2'd1].frame_length = sum[LEN_W-1:0];
			end
			new_cnt = need;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			op_s1   <= opcode_t'(s_tuser[1:0]);
			fin_s1  <= s_tuser[2];
			last_s1 <= s_tlast;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= CRC_INIT;
			bw_q      <= '0;
			addr_q    <= '0;
			ui_q      <= 1'b0;
			discard_q <= 1'b0;
		end else if (proceed) begin
			if (discard_q) begin
				if (last_s1) begin
					discard_q <= 1'b0;
				end
			end else if (addr_err || cap_err) begin
				crc_q     <= CRC_INIT;
				bw_q      <= '0;
				addr_q    <= '0;
				ui_q      <= 1'b0;
				discard_q <= !last_s1;
			end else if (last_s1) begin
				crc_q  <= CRC_INIT;
				bw_q   <= '0;
				addr_q <= '0;
				ui_q   <= 1'b0;
			end else begin
				crc_q <= crc_after;
				bw_q  <= sum[LEN_W-1:0];
				if ((op_s1 == OP_ADDR) && (addr_q < ADDR_FULL)) begin
					addr_q <= addr_q + 4'd1;
				end
				if (op_s1 == OP_CTRL) begin
					ui_q <= (byte_s1[1:0] == 2'b11);
				end
			end
		end
	end

	// result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (proceed) begin
			cnt_q <= new_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed) begin
			res_q[0] <= new_res[0];
			res_q[1] <= new_res[1];
			res_q[2] <= new_res[2];
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {6'd0, res_q[0].frame_length, res_q[0].out_byte};
	assign m_tuser  = res_q[0].status;
	assign m_tlast  = res_q[0].out_last;

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RES_DEPTH)
		else $error("result buffer count out of range");

	a_addr_sat: assert property (@(posedge clk) disable iff (!arst_n)
		addr_q <= ADDR_FULL)
		else $error("address count beyond saturation");

	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ST_OK)) |-> (m_tlast && (m_tdata == 24'd0)))
		else $error("error result not a closing zero result");

	a_len_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[17:8] == '0))
		else $error("frame length on a non-final result");

	a_single_err: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ST_OK)) |-> (cnt_q == 2'd1))
		else $error("error result not alone in buffer");
`endif

endmodule

[tb/ax25_frame_encoder_with_fcs_tb.sv]
// Self-checking testbench for the AX.25 frame encoder with FCS append and length check.
`timescale 1ns / 1ps

module ax25_frame_encoder_with_fcs_tb;
	import ax25e_pkg::*;

	localparam logic [2:0] CAPACITY_ADDR = 3'd0;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [7:0] data;
		opcode_t    op;
		logic       fin;
		logic       last;
	} byte_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] data_byte
	logic [2:0]  s_tuser = '0;   // [1:0] opcode, [2] final_address_byte
	logic        s_tlast = 1'b0; // last_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // [7:0] out_byte, [17:8] frame_length, [23:18] zero
	logic [1:0]  m_tuser;        // [1:0] status
	logic        m_tlast;        // out_last
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	ax25_frame_encoder_with_fcs DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// encoder model state
	logic [9:0]  capacity = CAP_RESET;
	logic [15:0] fcs_crc = CRC_INIT;
	logic [10:0] sent_count = '0;
	logic [3:0]  addr_seen = '0;
	logic        ui_frame = 1'b0;
	logic        skip_to_end = 1'b0;

	byte_item_t pending_bytes[$];
	byte_item_t frame_buf[$];
	res_t       encoded_q[$];
	byte_item_t cur_item;
	res_t       want_res;
	int         bytes_queued = 0;
	int         fail_count = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         hold_cnt = 0;
	logic       hold_start = 1'b0;
	int         cycle_cnt = 0;

	function automatic res_t make_res(logic [7:0] b, logic lst, status_t st, logic [9:0] len);
		res_t r;
		r.out_byte = b;
		r.out_last = lst;
		r.status = st;
		r.frame_length = len;
		return r;
	endfunction

	function automatic void clear_frame();
		fcs_crc = CRC_INIT;
		sent_count = '0;
		addr_seen = '0;
		ui_frame = 1'b0;
	endfunction

	// expected results for one accepted input byte
	function automatic void encode_byte(byte_item_t it);
		logic [7:0]  b;
		logic        emit;
		logic [10:0] need;
		logic [15:0] c;
		status_t     st;
		b = it.data;
		if (skip_to_end) begin
			if (it.last) begin
				skip_to_end = 1'b0;
			end
			return;
		end
		emit = (it.op != OP_PID) || ui_frame;
		need = {10'd0, emit} + (it.last ? 11'd2 : 11'd0);
		st = ST_OK;
		if ((it.op != OP_ADDR || it.last) && addr_seen < ADDR_FULL) begin
			st = ST_ADDRESSES;
		end else if (sent_count + need > {1'b0, capacity}) begin
			st = ST_CAPACITY;
		end
		if (st != ST_OK) begin
			encoded_q.push_back(make_res(8'h00, 1'b1, st, '0));
			clear_frame();
			skip_to_end = !it.last;
			return;
		end
		if (it.op == OP_ADDR) begin
			if (it.fin) begin
				b[0] = 1'b1;
			end
			if (addr_seen < ADDR_FULL) begin
				addr_seen = addr_seen + 1'b1;
			end
		end else if (it.op == OP_CTRL) begin
			ui_frame = (b[1:0] == 2'b11);
		end
		if (emit) begin
			c = fcs_crc ^ {8'h00, b};
			for (int i = 0; i < 8; i++) begin
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			end
			fcs_crc = c;
			sent_count = sent_count + 1'b1;
			encoded_q.push_back(make_res(b, 1'b0, ST_OK, '0));
		end
		if (it.last) begin
			c = ~fcs_crc;
			sent_count = sent_count + 11'd2;
			encoded_q.push_back(make_res(c[7:0], 1'b0, ST_OK, '0));
			encoded_q.push_back(make_res(c[15:8], 1'b1, ST_OK, sent_count[9:0]));
			clear_frame();
		end
	endfunction

	// input side
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				encode_byte(cur_item);
			end
			if (!s_tvalid || s_tready) begin
				if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur_item = pending_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= cur_item.data;
					s_tuser <= {cur_item.fin, cur_item.op};
					s_tlast <= cur_item.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// output side
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (encoded_q.size() == 0) begin
					$error("unexpected transfer: out_byte 0x%0h status %0d", m_tdata[7:0], m_tuser);
					fail_count++;
				end else begin
					want_res = encoded_q.pop_front();
					check_field("out_byte", want_res.out_byte, m_tdata[7:0]);
					check_field("out_last", want_res.out_last, m_tlast);
					check_field("status", want_res.status, m_tuser);
					check_field("frame_length", want_res.frame_length, m_tdata[17:8]);
				end
			end
			m_tready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_start) begin
			hold_cnt <= HOLD_CYCLES;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("[ax25_frame_encoder_with_fcs] ERROR");
			$finish;
		end
	end

	task automatic cfg_write(input logic [9:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAPACITY_ADDR;
		pwdata <= {22'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		capacity = value;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || s_tvalid || encoded_q.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic stage(input logic [7:0] d, input opcode_t op, input logic fin);
		frame_buf.push_back('{d, op, fin, 1'b0});
	endtask

	task automatic commit_frame(input logic mark_last);
		if (frame_buf.size() != 0) begin
			frame_buf[frame_buf.size() - 1].last = mark_last;
			foreach (frame_buf[i]) begin
				pending_bytes.push_back(frame_buf[i]);
			end
			bytes_queued += frame_buf.size();
			frame_buf.delete();
		end
	endtask

	// well-formed frame with random content, or at times an address field alone
	task automatic push_frame(input int max_info);
		int n_addr;
		int n_info;
		logic [7:0] ctrl;
		logic with_pid;
		logic pid_first;
		n_addr = ($urandom_range(0, 7) == 0) ? 7 * $urandom_range(2, 8) : 14;
		for (int i = 0; i < n_addr; i++) begin
			stage(8'($urandom_range(0, 255)), OP_ADDR, i == n_addr - 1);
		end
		if ($urandom_range(0, 19) == 0) begin
			commit_frame(1'b1);
			return;
		end
		ctrl = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 60) begin
			ctrl[1:0] = 2'b11;
		end
		with_pid = $urandom_range(0, 99) < 80;
		pid_first = $urandom_range(0, 9) == 0;
		if (with_pid && pid_first) begin
			stage(8'($urandom_range(0, 255)), OP_PID, 1'($urandom_range(0, 1)));
		end
		stage(ctrl, OP_CTRL, 1'($urandom_range(0, 1)));
		if (with_pid && !pid_first) begin
			stage(8'hF0, OP_PID, 1'b0);
		end
		n_info = $urandom_range(0, max_info);
		for (int i = 0; i < n_info; i++) begin
			stage(8'($urandom_range(0, 255)), OP_INFO, 1'($urandom_range(0, 1)));
		end
		commit_frame(1'b1);
	endtask

	// too few addresses, sometimes followed by a discarded tail
	task automatic push_broken_frame();
		int n_addr;
		int n_tail;
		n_addr = $urandom_range(0, 13);
		for (int i = 0; i < n_addr; i++) begin
			stage(8'($urandom_range(0, 255)), OP_ADDR, 1'($urandom_range(0, 1)));
		end
		if (n_addr != 0 && $urandom_range(0, 1)) begin
			commit_frame(1'b1);
			return;
		end
		stage(8'($urandom_range(0, 255)), opcode_t'($urandom_range(1, 3)),
			1'($urandom_range(0, 1)));
		if ($urandom_range(0, 1)) begin
			commit_frame(1'b1);
			return;
		end
		commit_frame(1'b0);
		n_tail = $urandom_range(1, 5);
		for (int i = 0; i < n_tail; i++) begin
			stage(8'($urandom_range(0, 255)), opcode_t'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)));
		end
		commit_frame(1'b1);
	endtask

	task automatic push_traffic(input int n_items, input int max_info);
		int start;
		int r;
		start = bytes_queued;
		while (bytes_queued - start < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				push_frame(max_info);
			end else if (r < 85) begin
				push_broken_frame();
			end else begin
				stage(8'($urandom_range(0, 255)), opcode_t'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)));
				commit_frame($urandom_range(0, 3) == 0);
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: clean UI frame with extreme info bytes
		for (int i = 0; i < 14; i++) begin
			stage((i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'h80 + 8'(i), OP_ADDR, i == 13);
		end
		stage(8'h03, OP_CTRL, 1'b0);
		stage(8'hF0, OP_PID, 1'b0);
		stage(8'h00, OP_INFO, 1'b0);
		stage(8'hFF, OP_INFO, 1'b0);
		commit_frame(1'b1);
		// control with no addresses, ends the frame at once
		stage(8'h13, OP_CTRL, 1'b0);
		commit_frame(1'b1);
		// short address field, then discard through the frame end
		stage(8'h96, OP_ADDR, 1'b0);
		stage(8'h70, OP_ADDR, 1'b1);
		stage(8'hAA, OP_INFO, 1'b0);
		commit_frame(1'b0);
		stage(8'h55, OP_PID, 1'b1);
		stage(8'h01, OP_ADDR, 1'b0);
		commit_frame(1'b1);
		wait_idle();

		// default capacity, no idling, then a long receiver hold-off
		push_traffic(50, 12);
		@(posedge clk);
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		wait_idle();

		cfg_write(10'd16);
		send_idle_pct = 60;
		recv_stall_pct = 0;
		push_traffic(35, 6);
		wait_idle();

		// info lengths straddle the capacity bound
		cfg_write(10'd40);
		send_idle_pct = 0;
		recv_stall_pct = 60;
		push_traffic(70, 24);
		wait_idle();

		cfg_write(10'd64);
		send_idle_pct = 29;
		recv_stall_pct = 29;
		// one frame filling the whole capacity
		for (int i = 0; i < 14; i++) begin
			stage(8'($urandom_range(0, 255)), OP_ADDR, i == 13);
		end
		stage(8'h03, OP_CTRL, 1'b0);
		stage(8'hF0, OP_PID, 1'b0);
		for (int i = 0; i < 46; i++) begin
			stage(8'($urandom_range(0, 255)), OP_INFO, 1'b0);
		end
		commit_frame(1'b1);
		wait_idle();

		cfg_write(10'd1023);
		push_traffic(60, 40);
		wait_idle();

		// zero capacity: every frame is rejected
		cfg_write(10'd0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		push_traffic(20, 4);
		wait_idle();

		cfg_write(10'd330);
		send_idle_pct = 60;
		recv_stall_pct = 60;
		push_traffic(35, 12);
		wait_idle();

		repeat (10) @(posedge clk);
		if (fail_count == 0 && encoded_q.size() == 0) begin
			$display("[ax25_frame_encoder_with_fcs] OK");
		end else begin
			$display("[ax25_frame_encoder_with_fcs] ERROR");
		end
		$finish;
	end

endmodule
